FILE: src/esk_pkg.sv
package esk_pkg;
  localparam int MAX_ELEMENTS = 16;
  localparam int VALUE_BITS   = 16;
  localparam int IDX_W        = 4;
  localparam int CNT_W        = 5;
  localparam int SUM_W        = 20;
  localparam int MAP_W        = 64;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_OVER  = 2'd3;
endpackage

FILE: src/esk_divk.sv
module esk_divk (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [esk_pkg::SUM_W-1:0] num,
  input  logic [esk_pkg::CNT_W-1:0] den,
  output logic                     done,
  output logic [esk_pkg::SUM_W-1:0] quo,
  output logic                     exact
);
  import esk_pkg::*;
  // Restoring divider, one quotient bit per cycle.
  logic [SUM_W-1:0] rem, q;
  logic [4:0]       cnt;
  logic             run;
  logic [SUM_W:0]   trial;

  assign trial = {1'b0, rem[SUM_W-2:0], q[SUM_W-1]} - {{(SUM_W-CNT_W+1){1'b0}}, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        rem <= '0;
        q   <= num;
        cnt <= 5'(SUM_W - 1);
      end else if (run) begin
        if (!trial[SUM_W]) begin
          rem <= trial[SUM_W-1:0];
          q   <= {q[SUM_W-2:0], 1'b1};
        end else begin
          rem <= {rem[SUM_W-2:0], q[SUM_W-1]};
          q   <= {q[SUM_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 5'd1;
      end
    end
  end

  assign quo   = q;
  assign exact = (rem == '0);
endmodule

FILE: src/equal_sum_k_partition_search.sv
// Sequence: an element item without last is stored in S_IDLE; a rejected element's result
// is strobed the cycle after it. A last item starts a bubble sort; each k then
// runs a division, a data-dependent search (buckets tried, placements and
// backtracks) and a build of the map.
// Throughput: one element item per cycle while loading; busy is high during search.
// Reset: rst is synchronous, active high; it clears the counters and flags. No stall.
module equal_sum_k_partition_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] value,
  input  logic        last,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [4:0]  parts_count,
  output logic [19:0] part_sum,
  output logic [63:0] bucket_map,
  output logic        end_of_run
);
  import esk_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SORT  = 11'b00000000010,
    S_KSET  = 11'b00000000100,
    S_DIV   = 11'b00000001000,
    S_CLR   = 11'b00000010000,
    S_STEP  = 11'b00000100000,
    S_SCAN  = 11'b00001000000,
    S_BACK  = 11'b00010000000,
    S_BACK2 = 11'b00100000000,
    S_MAP   = 11'b01000000000,
    S_FIN   = 11'b10000000000
  } state_t;

  state_t state;

  // Sorted copy of the elements and their load positions; small register arrays.
  logic [SUM_W-1:0] sv   [MAX_ELEMENTS];
  logic [IDX_W-1:0] orig [MAX_ELEMENTS];
  // Bucket sums live in flops so the duplicate check can compare all at once.
  logic [SUM_W-1:0] bsum [MAX_ELEMENTS];
  // Choice stack is a synchronous memory with a registered read; rd_addr tags
  // the entry that stack_rd currently holds.
  logic [CNT_W-1:0] stack_mem [MAX_ELEMENTS];
  logic [CNT_W-1:0] stack_rd, rd_addr;

  logic [CNT_W-1:0] count, n, k, found, depth, bidx, sa, sb;
  logic [SUM_W-1:0] total, target;
  logic [1:0]       err;
  logic [MAP_W-1:0] map;

  logic [SUM_W-1:0] value_ext;
  assign value_ext = {{(SUM_W-VALUE_BITS){1'b0}}, value[VALUE_BITS-1:0]};

  // Divider for total / k.
  logic             div_go, div_done, div_exact;
  logic [SUM_W-1:0] div_q;
  esk_divk u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(total), .den(k),
    .done(div_done), .quo(div_q), .exact(div_exact)
  );

  // Candidate bucket test: fits and has no equal-sum lower bucket.
  logic [SUM_W-1:0] cur_v;
  logic [SUM_W:0]   fit_sum;
  logic             dup, ok;
  always_comb begin
    cur_v   = sv[depth[IDX_W-1:0]];
    fit_sum = {1'b0, bsum[bidx[IDX_W-1:0]]} + {1'b0, cur_v};
    dup     = 1'b0;
    for (int j = 0; j < MAX_ELEMENTS; j++) begin
      if (CNT_W'(j) < bidx && bsum[j] == bsum[bidx[IDX_W-1:0]]) dup = 1'b1;
    end
    ok = (fit_sum <= {1'b0, target}) && !dup;
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    stack_rd <= stack_mem[depth[IDX_W-1:0]];
    rd_addr  <= depth;
  end

  always_ff @(posedge clk) begin
    logic [1:0]       err_next;
    logic [CNT_W-1:0] count_next;
    logic [SUM_W-1:0] total_next;
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      total  <= '0;
      err    <= '0;
      found  <= '0;
      strobe <= 1'b0;
      div_go <= 1'b0;
    end else begin
      strobe <= 1'b0;
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            err_next   = err;
            count_next = count;
            total_next = total;
            if (value_ext == '0) begin
              err_next[0] = 1'b1;
              if (!last) begin
                strobe <= 1'b1; status <= ST_ZERO; parts_count <= '0;
                part_sum <= '0; bucket_map <= '0; end_of_run <= 1'b0;
              end
            end else if (count >= CNT_W'(MAX_ELEMENTS)) begin
              err_next[1] = 1'b1;
              if (!last) begin
                strobe <= 1'b1; status <= ST_OVER; parts_count <= '0;
                part_sum <= '0; bucket_map <= '0; end_of_run <= 1'b0;
              end
            end else begin
              sv[count[IDX_W-1:0]]   <= value_ext;
              orig[count[IDX_W-1:0]] <= count[IDX_W-1:0];
              count_next = count + 5'd1;
              total_next = total + value_ext;
            end
            if (last) begin
              if (err_next != 2'b00) begin
                strobe <= 1'b1; status <= err_next[0] ? ST_ZERO : ST_OVER;
                parts_count <= '0; part_sum <= '0; bucket_map <= '0;
                end_of_run <= 1'b1;
                count_next = '0;
                total_next = '0;
                err_next   = '0;
              end else begin
                n     <= count_next;
                sa    <= '0;
                sb    <= '0;
                found <= '0;
                state <= S_SORT;
              end
            end
            count <= count_next;
            total <= total_next;
            err   <= err_next;
          end
        end
        // Stable bubble sort, descending: swap only on strict less-than.
        S_SORT: begin
          if (sb + 5'd1 < n) begin
            if (sv[sb[IDX_W-1:0]] < sv[sb[IDX_W-1:0] + IDX_W'(1)]) begin
              sv[sb[IDX_W-1:0]]              <= sv[sb[IDX_W-1:0] + IDX_W'(1)];
              sv[sb[IDX_W-1:0] + IDX_W'(1)]   <= sv[sb[IDX_W-1:0]];
              orig[sb[IDX_W-1:0]]            <= orig[sb[IDX_W-1:0] + IDX_W'(1)];
              orig[sb[IDX_W-1:0] + IDX_W'(1)] <= orig[sb[IDX_W-1:0]];
            end
            sb <= sb + 5'd1;
          end else begin
            sb <= '0;
            sa <= sa + 5'd1;
            if (sa + 5'd1 >= n) begin
              k     <= 5'd2;
              state <= S_KSET;
            end
          end
        end
        S_KSET: begin
          if (k > n) begin
            state <= S_FIN;
          end else begin
            div_go <= 1'b1;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_exact && sv[0] <= div_q) begin
              target <= div_q;
              bidx   <= '0;
              state  <= S_CLR;
            end else begin
              k     <= k + 5'd1;
              state <= S_KSET;
            end
          end
        end
        S_CLR: begin
          for (int j = 0; j < MAX_ELEMENTS; j++) bsum[j] <= '0;
          depth <= '0;
          bidx  <= '0;
          state <= S_STEP;
        end
        S_STEP: begin
          if (depth >= n) begin
            map   <= '0;
            sa    <= '0;
            state <= S_MAP;
          end else begin
            state <= S_SCAN;
          end
        end
        // Try one bucket per cycle starting from bidx.
        S_SCAN: begin
          if (bidx >= k) begin
            if (depth == '0) begin
              k     <= k + 5'd1;
              state <= S_KSET;
            end else begin
              depth <= depth - 5'd1;
              state <= S_BACK;
            end
          end else if (ok) begin
            bsum[bidx[IDX_W-1:0]]       <= fit_sum[SUM_W-1:0];
            stack_mem[depth[IDX_W-1:0]] <= bidx;
            depth <= depth + 5'd1;
            bidx  <= '0;
            state <= S_STEP;
          end else begin
            bidx <= bidx + 5'd1;
          end
        end
        S_BACK: state <= S_BACK2; // stack read in flight
        S_BACK2: begin
          bsum[stack_rd[IDX_W-1:0]] <= bsum[stack_rd[IDX_W-1:0]] - cur_v;
          bidx  <= stack_rd + 5'd1;
          state <= S_SCAN;
        end
        // Build the map one element at a time through the stack memory.
        // An entry is used once the read data belongs to its address.
        S_MAP: begin
          if (sa >= n) begin
            strobe <= 1'b1; status <= ST_FOUND; parts_count <= k;
            part_sum <= target; bucket_map <= map; end_of_run <= 1'b0;
            found <= found + 5'd1;
            k     <= k + 5'd1;
            state <= S_KSET;
          end else if (rd_addr == sa) begin
            map <= map | (MAP_W'(stack_rd[IDX_W-1:0])
                          << {orig[sa[IDX_W-1:0]], 2'b00});
            sa    <= sa + 5'd1;
            depth <= sa + 5'd1;
          end else begin
            depth <= sa;
          end
        end
        S_FIN: begin
          strobe <= 1'b1; status <= ST_DONE; parts_count <= found;
          part_sum <= '0; bucket_map <= '0; end_of_run <= 1'b1;
          count <= '0; total <= '0; err <= '0; found <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
